// ===== sv/rgb_to_hsv_top_macros.svh =====
// Assertion helpers for the RGB to HSV converter.
// All checks sample on the rising edge of clock and are off while reset is high.
`ifndef RGB_TO_HSV_TOP_MACROS_SVH
`define RGB_TO_HSV_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBHSV_ASSERT_NOW(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBHSV_ASSERT_NEXT(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`endif

// ===== sv/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

   // Field widths of one pixel and of one result.
   localparam int CHAN_W   = 8;
   localparam int HUE_W    = 9;
   localparam int PCT_W    = 7;

   // Offset into the sector numerator, up to twice the channel spread.
   localparam int X_W      = CHAN_W + 1;
   // Dividends: 60 times the offset, or 100 times a channel value.
   localparam int NUM_W    = 15;
   // Quotient bits resolved by the long division (quotients stay below 128).
   localparam int QUO_W    = 7;
   localparam int SH_W     = 3;

   // Pipeline depth: front end, scaling, three division stages, output.
   localparam int STAGES   = 6;
   localparam int DIV_STAGES = 3;
   localparam int OUT_STAGE  = STAGES - 1;

   // Scale factors.
   localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60);
   localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);

   // Hue offset of each sector, in degrees, applied after the division.
   localparam logic [HUE_W-1:0] BASE_RED_UP   = HUE_W'(0);
   localparam logic [HUE_W-1:0] BASE_GREEN    = HUE_W'(60);
   localparam logic [HUE_W-1:0] BASE_BLUE     = HUE_W'(180);
   localparam logic [HUE_W-1:0] BASE_RED_DOWN = HUE_W'(300);

   localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(360);
   localparam logic [PCT_W-1:0] PCT_LIMIT = PCT_W'(100);

   // Front-end stage: spread, max, sector offset and sector base.
   typedef struct packed {
      logic [CHAN_W-1:0] d;
      logic [CHAN_W-1:0] mx;
      logic [X_W-1:0]    x;
      logic [HUE_W-1:0]  base;
   } front_type;

   // Scaling stage: the three dividends.
   typedef struct packed {
      logic [NUM_W-1:0]  hue_num;
      logic [NUM_W-1:0]  sat_num;
      logic [NUM_W-1:0]  bright_num;
      logic [CHAN_W-1:0] d;
      logic [CHAN_W-1:0] mx;
      logic [HUE_W-1:0]  base;
   } num_type;

   // Division stages: partial remainders and quotients of both divisions.
   typedef struct packed {
      logic [NUM_W-1:0]  hue_rem;
      logic [QUO_W-1:0]  hue_q;
      logic [NUM_W-1:0]  sat_rem;
      logic [QUO_W-1:0]  sat_q;
      logic [CHAN_W-1:0] d;
      logic [CHAN_W-1:0] mx;
      logic [HUE_W-1:0]  base;
      logic [PCT_W-1:0]  bright;
   } div_type;

   // One restoring step on both divisions: hue by d, saturation by max.
   function automatic div_type div_step(div_type src, logic [SH_W-1:0] sh);
      div_type          res;
      logic [NUM_W-1:0] hue_dv;
      logic [NUM_W-1:0] sat_dv;
      res    = src;
      hue_dv = NUM_W'(src.d) << sh;
      sat_dv = NUM_W'(src.mx) << sh;
      if (src.hue_rem >= hue_dv) begin
         res.hue_rem   = src.hue_rem - hue_dv;
         res.hue_q[sh] = 1'b1;
      end
      if (src.sat_rem >= sat_dv) begin
         res.sat_rem   = src.sat_rem - sat_dv;
         res.sat_q[sh] = 1'b1;
      end
      return res;
   endfunction

   // Floor of n / 255 for n below 32640 (results up to 127), by the add-and-shift identity.
   function automatic logic [PCT_W-1:0] div_by_255(logic [NUM_W-1:0] n);
      logic [NUM_W:0] sum;
      sum = (NUM_W+1)'(n) + (NUM_W+1)'(n >> 8) + (NUM_W+1)'(1);
      return PCT_W'(sum >> 8);
   endfunction

endpackage

// ===== sv/rgb_to_hsv_top.sv =====
// RGB to HSV pixel converter.
// Input channel (req_): one 8-bit red, green and blue pixel per beat, handshake
// by req_valid and req_stall. Result channel (rsp_): hue in degrees (0..359),
// saturation and brightness in percent (0..100), handshake by rsp_valid and
// rsp_stall. Every input beat gives exactly one result beat, in order.
// Throughput is one pixel per cycle while the output is not stalled: the six
// register stages (front end, scaling, three two-bit division stages, output)
// each move every cycle, and the two 7-bit long divisions resolve two quotient
// bits in each division stage and the last bit in the output stage.
// Reset (synchronous, active high) empties the pipeline; no result is pending
// after it. When the receiver stalls, the output beat holds, and stages behind
// it keep moving until they fill up; bubbles are squeezed out. req_stall rises
// only once all six stages hold a pixel, and it follows rsp_stall in the same
// cycle, so no pixel is dropped or repeated.
`include "rgb_to_hsv_top_macros.svh"

module rgb_to_hsv_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rgbhsv_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::PCT_W-1:0]  rsp_saturation,
   output logic [rgbhsv_pkg::PCT_W-1:0]  rsp_brightness
);

   logic [rgbhsv_pkg::STAGES-1:0] valid_ff;
   logic [rgbhsv_pkg::STAGES-1:0] valid_in;
   logic [rgbhsv_pkg::STAGES:0]   ready;

   rgbhsv_pkg::front_type front_ff;
   rgbhsv_pkg::front_type front_in;
   rgbhsv_pkg::num_type   num_ff;
   rgbhsv_pkg::num_type   num_in;
   rgbhsv_pkg::div_type   div_first;
   rgbhsv_pkg::div_type   div_ff [rgbhsv_pkg::DIV_STAGES];
   rgbhsv_pkg::div_type   div_in [rgbhsv_pkg::DIV_STAGES];
   rgbhsv_pkg::div_type   div_last;

   logic [rgbhsv_pkg::HUE_W-1:0] hue_ff;
   logic [rgbhsv_pkg::HUE_W-1:0] hue_in;
   logic [rgbhsv_pkg::PCT_W-1:0] sat_ff;
   logic [rgbhsv_pkg::PCT_W-1:0] sat_in;
   logic [rgbhsv_pkg::PCT_W-1:0] bright_ff;
   logic [rgbhsv_pkg::PCT_W-1:0] bright_in;

   logic [rgbhsv_pkg::CHAN_W-1:0] mx;
   logic [rgbhsv_pkg::CHAN_W-1:0] mn;
   logic [rgbhsv_pkg::CHAN_W-1:0] d;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      ready[rgbhsv_pkg::STAGES] = !rsp_stall;
      for (int i = rgbhsv_pkg::STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < rgbhsv_pkg::STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < rgbhsv_pkg::STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Front end: max, min, spread and the hue sector. Green wins ties, then red.
   // Each sector is rewritten as base + floor(60 * x / d) with x in 0..2d.
   always_comb begin
      mx = req_red;
      if (req_green > mx) begin
         mx = req_green;
      end
      if (req_blue > mx) begin
         mx = req_blue;
      end
      mn = req_red;
      if (req_green < mn) begin
         mn = req_green;
      end
      if (req_blue < mn) begin
         mn = req_blue;
      end
      d = mx - mn;

      front_in.d  = d;
      front_in.mx = mx;
      if (d == '0) begin
         front_in.x    = '0;
         front_in.base = '0;
      end else if (mx == req_green) begin
         front_in.x    = rgbhsv_pkg::X_W'(({1'b0, req_blue} + {1'b0, d}) - {1'b0, req_red});
         front_in.base = rgbhsv_pkg::BASE_GREEN;
      end else if (mx == req_red) begin
         if (req_green >= req_blue) begin
            front_in.x    = rgbhsv_pkg::X_W'(req_green - req_blue);
            front_in.base = rgbhsv_pkg::BASE_RED_UP;
         end else begin
            front_in.x    = rgbhsv_pkg::X_W'(({1'b0, req_green} + {1'b0, d})
                                             - {1'b0, req_blue});
            front_in.base = rgbhsv_pkg::BASE_RED_DOWN;
         end
      end else begin
         front_in.x    = rgbhsv_pkg::X_W'(({1'b0, req_red} + {1'b0, d}) - {1'b0, req_green});
         front_in.base = rgbhsv_pkg::BASE_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         front_ff <= front_in;
      end
   end

   // Scaling: the three dividends by constant multiplies.
   always_comb begin
      num_in.hue_num    = rgbhsv_pkg::NUM_W'(front_ff.x) * rgbhsv_pkg::HUE_SCALE;
      num_in.sat_num    = rgbhsv_pkg::NUM_W'(front_ff.d) * rgbhsv_pkg::PCT_SCALE;
      num_in.bright_num = rgbhsv_pkg::NUM_W'(front_ff.mx) * rgbhsv_pkg::PCT_SCALE;
      num_in.d          = front_ff.d;
      num_in.mx         = front_ff.mx;
      num_in.base       = front_ff.base;
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         num_ff <= num_in;
      end
   end

   // Division entry: load the dividends as remainders; brightness divides by
   // the constant 255 here and then rides along.
   always_comb begin
      div_first.hue_rem = num_ff.hue_num;
      div_first.hue_q   = '0;
      div_first.sat_rem = num_ff.sat_num;
      div_first.sat_q   = '0;
      div_first.d       = num_ff.d;
      div_first.mx      = num_ff.mx;
      div_first.base    = num_ff.base;
      div_first.bright  = rgbhsv_pkg::div_by_255(num_ff.bright_num);
   end

   // Three division stages, two quotient bits each, from the top bit down.
   for (genvar k = 0; k < rgbhsv_pkg::DIV_STAGES; k++) begin : g_div
      localparam logic [rgbhsv_pkg::SH_W-1:0] ShHi =
         rgbhsv_pkg::SH_W'(rgbhsv_pkg::QUO_W - 1 - 2*k);
      localparam logic [rgbhsv_pkg::SH_W-1:0] ShLo =
         rgbhsv_pkg::SH_W'(rgbhsv_pkg::QUO_W - 2 - 2*k);

      if (k == 0) begin : g_head
         assign div_in[k] = rgbhsv_pkg::div_step(rgbhsv_pkg::div_step(div_first, ShHi), ShLo);
      end else begin : g_body
         assign div_in[k] = rgbhsv_pkg::div_step(rgbhsv_pkg::div_step(div_ff[k-1], ShHi), ShLo);
      end

      always_ff @(posedge clock) begin
         if (ready[k+2]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Output stage: last quotient bit, sector base, grey and black pixels.
   always_comb begin
      div_last  = rgbhsv_pkg::div_step(div_ff[rgbhsv_pkg::DIV_STAGES-1], '0);
      hue_in    = (div_last.d == '0) ? '0
                  : div_last.base + rgbhsv_pkg::HUE_W'(div_last.hue_q);
      sat_in    = (div_last.mx == '0) ? '0 : div_last.sat_q;
      bright_in = div_last.bright;
   end

   always_ff @(posedge clock) begin
      if (ready[rgbhsv_pkg::OUT_STAGE]) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   assign rsp_valid      = valid_ff[rgbhsv_pkg::OUT_STAGE];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

   // Flags watched by the checks below.
   logic                hue_ok;
   logic                pct_ok;
   logic                div_full;
   logic                div_blocked;
   rgbhsv_pkg::div_type div_tail;

   assign hue_ok      = rsp_hue < rgbhsv_pkg::HUE_LIMIT;
   assign pct_ok      = (rsp_saturation <= rgbhsv_pkg::PCT_LIMIT)
                        && (rsp_brightness <= rgbhsv_pkg::PCT_LIMIT);
   assign div_full    = valid_ff[rgbhsv_pkg::OUT_STAGE-1];
   assign div_blocked = div_full && !ready[rgbhsv_pkg::OUT_STAGE-1];
   assign div_tail    = div_ff[rgbhsv_pkg::DIV_STAGES-1];

   // Results stay within their ranges.
   `RGBHSV_ASSERT_NOW(a_hue_range, rsp_valid, hue_ok, "hue out of range")
   `RGBHSV_ASSERT_NOW(a_pct_range, rsp_valid, pct_ok, "percent out of range")
   // The input side is held off only when every stage holds a pixel.
   `RGBHSV_ASSERT_NOW(a_full_on_stall, req_stall, &valid_ff, "input stalled with a bubble")
   // A blocked last division stage keeps its pixel.
   `RGBHSV_ASSERT_NEXT(a_div_hold, div_blocked, div_full && $stable(div_tail), "pixel lost")

endmodule

// ===== test/rgb_to_hsv_top_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_top_tb;

   localparam int RANDOM_PIXELS = 1000;
   localparam int QUIET_TAIL    = 120;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [rgbhsv_pkg::CHAN_W-1:0] red;
      logic [rgbhsv_pkg::CHAN_W-1:0] green;
      logic [rgbhsv_pkg::CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [rgbhsv_pkg::HUE_W-1:0] hue;
      logic [rgbhsv_pkg::PCT_W-1:0] saturation;
      logic [rgbhsv_pkg::PCT_W-1:0] brightness;
   } hsv_type;

   // One directed row: a pixel, and a typed-in result where has_want is set.
   typedef struct packed {
      pixel_type pixel;
      bit        has_want;
      hsv_type   want;
   } color_row_type;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_GREY,
      SHAPE_TIE,
      SHAPE_EXTREME,
      SHAPE_NEAR,
      SHAPE_ZERO
   } shape_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [rgbhsv_pkg::CHAN_W-1:0] req_red;
   logic [rgbhsv_pkg::CHAN_W-1:0] req_green;
   logic [rgbhsv_pkg::CHAN_W-1:0] req_blue;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [rgbhsv_pkg::HUE_W-1:0]  rsp_hue;
   logic [rgbhsv_pkg::PCT_W-1:0]  rsp_saturation;
   logic [rgbhsv_pkg::PCT_W-1:0]  rsp_brightness;

   hsv_type hsv_want_q [$];
   int   fail_count      = 0;
   int   pixels_sent     = 0;
   int   results_checked = 0;
   int   input_stalls    = 0;
   int   cycle_count     = 0;
   int   idle_pct        = 0;
   int   stall_left      = 0;
   bit   hold_start      = 1'b0;
   bit   hold_done       = 1'b0;
   bit   holding         = 1'b0;

   // Primaries, secondaries, grey levels and the darkest pixels have results
   // that can be read off directly; the rest go through the predictor.
   color_row_type color_rows [22] = '{
      '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd0,   7'd0  }},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0,   7'd0,   7'd100}},
      '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd100, 7'd100}},
      '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{9'd120, 7'd100, 7'd100}},
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{9'd240, 7'd100, 7'd100}},
      '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{9'd60,  7'd100, 7'd100}},
      '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{9'd180, 7'd100, 7'd100}},
      '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{9'd300, 7'd100, 7'd100}},
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{9'd0,   7'd0,   7'd50 }},
      '{'{8'd1,   8'd0,   8'd0  }, 1'b1, '{9'd0,   7'd100, 7'd0  }},
      '{'{8'd200, 8'd10,  8'd50 }, 1'b0, '0},
      '{'{8'd200, 8'd200, 8'd10 }, 1'b0, '0},
      '{'{8'd50,  8'd20,  8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd254, 8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd1,   8'd255}, 1'b0, '0},
      '{'{8'd100, 8'd0,   8'd1  }, 1'b0, '0},
      '{'{8'd3,   8'd2,   8'd1  }, 1'b0, '0},
      '{'{8'd85,  8'd170, 8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd128, 8'd128}, 1'b0, '0},
      '{'{8'd1,   8'd1,   8'd0  }, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0}
   };

   rgb_to_hsv_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always #4 clock = ~clock;

   // Exact floor of hue, saturation and brightness in integer arithmetic.
   // Every numerator below is kept non-negative so the division is a floor.
   function automatic hsv_type convert_rgb(pixel_type px);
      int      r;
      int      g;
      int      b;
      int      mx;
      int      mn;
      int      d;
      int      h;
      hsv_type res;
      r  = int'(px.red);
      g  = int'(px.green);
      b  = int'(px.blue);
      mx = (r > g) ? r : g;
      mx = (b > mx) ? b : mx;
      mn = (r < g) ? r : g;
      mn = (b < mn) ? b : mn;
      d  = mx - mn;
      // Green is tested first, then red, so ties for max resolve that way.
      if (d == 0)
         h = 0;
      else if (mx == g)
         h = (60 * (b + d - r) + 60 * d) / d;
      else if (mx == r)
         h = (g >= b) ? (60 * (g - b)) / d : (360 * d - 60 * (b - g)) / d;
      else
         h = (60 * (r + d - g) + 180 * d) / d;
      res.hue        = rgbhsv_pkg::HUE_W'(h);
      res.saturation = (mx == 0) ? '0 : rgbhsv_pkg::PCT_W'((100 * d) / mx);
      res.brightness = rgbhsv_pkg::PCT_W'((100 * mx) / 255);
      return res;
   endfunction

   function automatic logic [rgbhsv_pkg::CHAN_W-1:0] extreme_or_any();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return rgbhsv_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Random pixel, biased toward grey, ties for max, extremes, tiny spreads and a zero channel.
   function automatic pixel_type random_pixel();
      pixel_type                     px;
      shape_type                     shape;
      logic [rgbhsv_pkg::CHAN_W-1:0] lvl;
      int                            pick;
      pick     = $urandom_range(0, 8);
      shape    = (pick > int'(SHAPE_ZERO)) ? SHAPE_ANY : shape_type'(pick);
      px.red   = rgbhsv_pkg::CHAN_W'($urandom_range(0, 255));
      px.green = rgbhsv_pkg::CHAN_W'($urandom_range(0, 255));
      px.blue  = rgbhsv_pkg::CHAN_W'($urandom_range(0, 255));
      lvl      = rgbhsv_pkg::CHAN_W'($urandom_range(0, 255));
      pick     = $urandom_range(0, 2);
      case (shape)
         SHAPE_GREY: begin
            px = '{lvl, lvl, lvl};
         end
         SHAPE_TIE: begin
            px = '{lvl, lvl, lvl};
            case (pick)
               0: px.blue  = rgbhsv_pkg::CHAN_W'($urandom_range(0, int'(lvl)));
               1: px.green = rgbhsv_pkg::CHAN_W'($urandom_range(0, int'(lvl)));
               default: px.red = rgbhsv_pkg::CHAN_W'($urandom_range(0, int'(lvl)));
            endcase
         end
         SHAPE_EXTREME: begin
            px = '{extreme_or_any(), extreme_or_any(), extreme_or_any()};
         end
         SHAPE_NEAR: begin
            lvl      = rgbhsv_pkg::CHAN_W'($urandom_range(0, 252));
            px.red   = lvl + rgbhsv_pkg::CHAN_W'($urandom_range(0, 3));
            px.green = lvl + rgbhsv_pkg::CHAN_W'($urandom_range(0, 3));
            px.blue  = lvl + rgbhsv_pkg::CHAN_W'($urandom_range(0, 3));
         end
         SHAPE_ZERO: begin
            case (pick)
               0: px.red   = '0;
               1: px.green = '0;
               default: px.blue = '0;
            endcase
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   // Offer one pixel beat, maybe after an idle burst, and log its result once
   // the beat is taken.
   task automatic offer_pixel(input pixel_type px, input hsv_type want);
      int gap;
      if (idle_pct != 0 && !holding && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_red   <= px.red;
      req_green <= px.green;
      req_blue  <= px.blue;
      @(posedge clock);
      while (req_stall) begin
         input_stalls++;
         @(posedge clock);
      end
      hsv_want_q.push_back(want);
      pixels_sent++;
   endtask

   // Output stall: random bursts, and one long hold requested by the sender.
   always @(negedge clock) begin
      if (hold_start && !hold_done) begin
         hold_done  = 1'b1;
         holding    = 1'b1;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         holding = 1'b0;
         rsp_stall <= 1'b0;
         if (!reset && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 6);
      end
   end

   // Compare each result beat against the oldest pending expectation.
   always @(posedge clock) begin : check_results
      hsv_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hsv_want_q.size() == 0) begin
            $error("result beat with no pixel pending: hue %0d sat %0d bright %0d",
                   rsp_hue, rsp_saturation, rsp_brightness);
            fail_count++;
         end else begin
            want = hsv_want_q.pop_front();
            results_checked++;
            if (rsp_hue !== want.hue) begin
               $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
               fail_count++;
            end
            if (rsp_saturation !== want.saturation) begin
               $error("saturation: expected %0d, got %0d", want.saturation,
                      rsp_saturation);
               fail_count++;
            end
            if (rsp_brightness !== want.brightness) begin
               $error("brightness: expected %0d, got %0d", want.brightness,
                      rsp_brightness);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      pixel_type px;
      hsv_type   want;
      int        total;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      rsp_stall = 1'b0;
      total     = $size(color_rows) + RANDOM_PIXELS;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows first, with random idling on both sides.
      idle_pct = 25;
      foreach (color_rows[i]) begin
         px   = color_rows[i].pixel;
         want = color_rows[i].has_want ? color_rows[i].want : convert_rgb(px);
         offer_pixel(px, want);
      end

      // Random pixels; idle density changes every 64 beats, none in the tail.
      for (int n = $size(color_rows); n < total; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 15;
               2: idle_pct = 35;
               default: idle_pct = 60;
            endcase
         end
         if (n >= total - QUIET_TAIL)
            idle_pct = 0;
         if (n == HOLD_AT)
            hold_start = 1'b1;
         px = random_pixel();
         offer_pixel(px, convert_rgb(px));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Let the pipeline drain, then watch for stray beats.
      while (hsv_want_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels (%0d directed), checked %0d results.",
               pixels_sent, $size(color_rows), results_checked);
      $display("Input saw %0d stalled cycles, including a %0d-cycle output hold.",
               input_stalls, HOLD_CYCLES);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rgbhsv_pkg.sv
sv/rgb_to_hsv_top.sv
test/rgb_to_hsv_top_tb.sv
